@@ rtl/fill_tile_rect_generator_top_macros.svh @@
// Assertion macros used by the checker file of the tile rectangle generator.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef FILL_TILE_RECT_GENERATOR_TOP_MACROS_SVH
`define FILL_TILE_RECT_GENERATOR_TOP_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define FTRG_ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block's own clock and reset.
`define FTRG_ASSERT(label, prop, msg) `FTRG_ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/ftrg_pkg.sv @@
// Package of the tile rectangle generator: widths, register indexes, types.
// Used by the divider, the top level and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ftrg_pkg;

  // Default size limit; sizes above it saturate.
  localparam int unsigned DefaultMaxDimension = 4096;

  // Configuration port.
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 13;

  localparam logic [CfgIndexW-1:0] CfgSourceWidth  = 3'd0;
  localparam logic [CfgIndexW-1:0] CfgSourceHeight = 3'd1;
  localparam logic [CfgIndexW-1:0] CfgTargetWidth  = 3'd2;
  localparam logic [CfgIndexW-1:0] CfgTargetHeight = 3'd3;
  localparam logic [CfgIndexW-1:0] CfgOffsetX      = 3'd4;
  localparam logic [CfgIndexW-1:0] CfgOffsetY      = 3'd5;
  localparam logic [CfgIndexW-1:0] CfgFillMode     = 3'd6;

  // Shared divider: the dividend holds an offset magnitude or a size sum, the divisor one size.
  localparam int unsigned DivDividendW = 15;
  localparam int unsigned DivDivisorW  = 13;
  localparam int unsigned DivSteps     = DivDividendW;
  localparam int unsigned DivCntW      = $clog2(DivSteps + 1);

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } ftrg_state_e;

  // Per-axis tiling rule.
  typedef enum logic [1:0] {
    AXIS_PLAIN,
    AXIS_REPEAT,
    AXIS_STRETCH
  } axis_mode_e;

  // One axis of a tile rectangle.
  typedef struct packed {
    logic [11:0] src;
    logic [12:0] slen;
    logic [11:0] dst;
    logic [12:0] dlen;
  } tile_axis_t;

endpackage

`default_nettype wire

@@ rtl/ftrg_divider.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on ftrg_pkg for its operand widths and step count.
`timescale 1ns / 1ps
`default_nettype none

module ftrg_divider (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic [ftrg_pkg::DivDividendW-1:0]  dividend_i,
  input  wire logic [ftrg_pkg::DivDivisorW-1:0]   divisor_i,
  output      logic                               done_o,
  output      logic [ftrg_pkg::DivDividendW-1:0]  quotient_o,
  output      logic [ftrg_pkg::DivDivisorW-1:0]   remainder_o
);

  logic [ftrg_pkg::DivDividendW-1:0] quo_q, quo_d;
  logic [ftrg_pkg::DivDivisorW-1:0]  rem_q, rem_d;
  logic [ftrg_pkg::DivDivisorW-1:0]  dsr_q;
  logic [ftrg_pkg::DivCntW-1:0]      cnt_q;
  logic                              done_q;
  logic [ftrg_pkg::DivDivisorW:0]    trial;
  logic [ftrg_pkg::DivDivisorW:0]    diff;
  logic                              fits;

  // One restoring step: bring down the next dividend bit and try the divisor.
  always_comb begin
    trial = {rem_q, quo_q[ftrg_pkg::DivDividendW-1]};
    fits  = trial >= {1'b0, dsr_q};
    diff  = trial - {1'b0, dsr_q};
    rem_d = fits ? diff[ftrg_pkg::DivDivisorW-1:0] : trial[ftrg_pkg::DivDivisorW-1:0];
    quo_d = {quo_q[ftrg_pkg::DivDividendW-2:0], fits};
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= ftrg_pkg::DivCntW'(ftrg_pkg::DivSteps);
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == ftrg_pkg::DivCntW'(1));
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - ftrg_pkg::DivCntW'(1);
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

@@ rtl/fill_tile_rect_generator_top.sv @@
// Tile rectangle generator. A request with restart set computes, per axis, the
// repeat phase and tile count with one shared serial divider (four divisions of
// 15 steps each) and answers once the last division is done; a request with
// restart clear hands out the next tile of the walk from the running counters
// and is answered in the cycle after acceptance, so such requests can follow
// one per cycle while the output side keeps up. The walk goes row by row, left
// to right within a row, and final_tile marks its last tile; a finished or
// empty walk answers with every field zero. A write to any configuration
// register ends the walk in progress. Depends on ftrg_pkg and ftrg_divider.
`timescale 1ns / 1ps
`default_nettype none

module fill_tile_rect_generator_top #(
  parameter int unsigned MAX_DIMENSION = ftrg_pkg::DefaultMaxDimension
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration port
  input  wire logic                            cfg_we_i,
  input  wire logic [ftrg_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  wire logic [ftrg_pkg::CfgDataW-1:0]   cfg_data_i,
  // request channel
  input  wire logic                            in_valid_i,
  output      logic                            in_stall_o,
  input  wire logic                            restart_i,
  // result channel
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      logic                            tile_valid_o,
  output      logic [11:0]                     src_left_o,
  output      logic [11:0]                     src_top_o,
  output      logic [12:0]                     src_span_x_o,
  output      logic [12:0]                     src_span_y_o,
  output      logic [11:0]                     dst_left_o,
  output      logic [11:0]                     dst_top_o,
  output      logic [12:0]                     dst_span_x_o,
  output      logic [12:0]                     dst_span_y_o,
  output      logic                            final_tile_o
);

  localparam logic [12:0] SizeCap = (MAX_DIMENSION > 8191) ? 13'd8191 : 13'(MAX_DIMENSION);

  // Plain placement helpers: source start, destination start, clipped span.
  function automatic logic [13:0] plain_src(input logic signed [12:0] o);
    return o[12] ? (14'd0 - {o[12], o}) : 14'd0;
  endfunction

  function automatic logic [12:0] plain_dst(input logic signed [12:0] o);
    return o[12] ? 13'd0 : o;
  endfunction

  function automatic logic signed [14:0] plain_len(input logic [12:0] s,
                                                   input logic [12:0] d,
                                                   input logic signed [12:0] o);
    logic signed [14:0] a;
    logic signed [14:0] b;
    a = $signed({2'b00, s}) - $signed({1'b0, plain_src(o)});
    b = $signed({2'b00, d}) - $signed({2'b00, plain_dst(o)});
    return (a < b) ? a : b;
  endfunction

  function automatic ftrg_pkg::axis_mode_e axis_mode(input logic rep, input logic str);
    return rep ? ftrg_pkg::AXIS_REPEAT : (str ? ftrg_pkg::AXIS_STRETCH : ftrg_pkg::AXIS_PLAIN);
  endfunction

  // Tile count of one axis from its phase and the quotient of the second division.
  function automatic logic [13:0] axis_count(input ftrg_pkg::axis_mode_e m,
                                             input logic [12:0] s,
                                             input logic [12:0] d,
                                             input logic signed [12:0] o,
                                             input logic [12:0] p,
                                             input logic [14:0] q);
    logic [13:0] n;
    n = '0;
    if (s != 13'd0 && d != 13'd0) begin
      case (m)
        ftrg_pkg::AXIS_REPEAT: begin
          n = {13'd0, p != 13'd0} + ((d > p) ? q[13:0] : 14'd0);
        end
        ftrg_pkg::AXIS_STRETCH: begin
          n = 14'd1;
        end
        default: begin
          n = (plain_len(s, d, o) > 15'sd0) ? 14'd1 : 14'd0;
        end
      endcase
    end
    return n;
  endfunction

  // One axis of the current tile.
  function automatic ftrg_pkg::tile_axis_t axis_tile(input ftrg_pkg::axis_mode_e m,
                                                     input logic [12:0] s,
                                                     input logic [12:0] d,
                                                     input logic signed [12:0] o,
                                                     input logic [12:0] p,
                                                     input logic first,
                                                     input logic [14:0] pos);
    ftrg_pkg::tile_axis_t t;
    logic signed [15:0]   room;
    logic [12:0]          span;
    logic [13:0]          ps;
    logic [12:0]          pd;
    logic signed [14:0]   len;
    t    = '0;
    room = $signed({3'b000, d}) - $signed({1'b0, pos});
    ps   = plain_src(o);
    pd   = plain_dst(o);
    len  = plain_len(s, d, o);
    span = '0;
    case (m)
      ftrg_pkg::AXIS_REPEAT: begin
        if (p != 13'd0 && first) begin
          // Leading partial tile from the source's far edge.
          span   = (p < d) ? p : d;
          t.src  = 12'(s - p);
          t.dst  = '0;
        end else begin
          span   = (room > $signed({3'b000, s})) ? s : room[12:0];
          t.src  = '0;
          t.dst  = pos[11:0];
        end
        t.slen = span;
        t.dlen = span;
      end
      ftrg_pkg::AXIS_STRETCH: begin
        t.slen = s;
        t.dlen = d;
      end
      default: begin
        t.src  = ps[11:0];
        t.dst  = pd[11:0];
        t.slen = len[12:0];
        t.dlen = len[12:0];
      end
    endcase
    return t;
  endfunction

  // Configuration registers.
  logic [12:0]        src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic signed [12:0] off_x_q, off_y_q;
  logic [3:0]         mode_q;
  logic               cfg_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= 13'd1;
      src_h_q <= 13'd1;
      dst_w_q <= 13'd1;
      dst_h_q <= 13'd1;
      off_x_q <= '0;
      off_y_q <= '0;
      mode_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ftrg_pkg::CfgSourceWidth:  src_w_q <= cfg_data_i;
        ftrg_pkg::CfgSourceHeight: src_h_q <= cfg_data_i;
        ftrg_pkg::CfgTargetWidth:  dst_w_q <= cfg_data_i;
        ftrg_pkg::CfgTargetHeight: dst_h_q <= cfg_data_i;
        ftrg_pkg::CfgOffsetX:      off_x_q <= cfg_data_i;
        ftrg_pkg::CfgOffsetY:      off_y_q <= cfg_data_i;
        ftrg_pkg::CfgFillMode:     mode_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign cfg_hit = cfg_we_i && (cfg_index_i <= ftrg_pkg::CfgFillMode);

  // Saturated sizes and axis modes.
  logic [12:0]          sw, sh, dw, dh;
  ftrg_pkg::axis_mode_e mode_x, mode_y;

  assign sw     = (src_w_q > SizeCap) ? SizeCap : src_w_q;
  assign sh     = (src_h_q > SizeCap) ? SizeCap : src_h_q;
  assign dw     = (dst_w_q > SizeCap) ? SizeCap : dst_w_q;
  assign dh     = (dst_h_q > SizeCap) ? SizeCap : dst_h_q;
  assign mode_x = axis_mode(mode_q[0], mode_q[2]);
  assign mode_y = axis_mode(mode_q[1], mode_q[3]);

  // Sequencer and walk state.
  ftrg_pkg::ftrg_state_e state_q, state_d;
  logic [1:0]            step_q;
  logic [12:0]           phase_x_q, phase_y_q;
  logic [13:0]           col_cnt_q, row_cnt_q;
  logic [13:0]           col_idx_q, row_idx_q;
  logic [14:0]           pos_x_q, pos_y_q;
  logic                  walk_done_q;
  logic                  out_valid_q;

  logic in_accept;
  logic out_free;
  logic do_emit;
  logic div_start;
  logic div_done;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ftrg_pkg::ST_IDLE) || !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign do_emit    = (in_accept && !restart_i) || ((state_q == ftrg_pkg::ST_EMIT) && out_free);

  // Next state: a restart runs four divisions, then emits its first tile or, for an empty walk, the all-zero answer.
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    case (state_q)
      ftrg_pkg::ST_IDLE: begin
        if (in_accept && restart_i) begin
          state_d = ftrg_pkg::ST_DIV_START;
        end
      end
      ftrg_pkg::ST_DIV_START: begin
        div_start = 1'b1;
        state_d   = ftrg_pkg::ST_DIV_WAIT;
      end
      ftrg_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = (step_q == 2'd3) ? ftrg_pkg::ST_EMIT : ftrg_pkg::ST_DIV_START;
        end
      end
      ftrg_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = ftrg_pkg::ST_IDLE;
        end
      end
      default: state_d = ftrg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ftrg_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ftrg_pkg::ST_IDLE) begin
        step_q <= '0;
      end else if (state_q == ftrg_pkg::ST_DIV_WAIT && div_done) begin
        step_q <= step_q + 2'd1;
      end
    end
  end

  // Divider operands: even steps reduce the offset, odd steps count full tiles.
  logic                axis_y;
  logic [12:0]         s_sel, d_sel, p_sel;
  logic signed [12:0]  o_sel;
  ftrg_pkg::axis_mode_e m_sel;
  logic [13:0]         abs_o;
  logic [14:0]         numer;
  logic [14:0]         div_dividend;
  logic [14:0]         div_quo;
  logic [12:0]         div_rem;
  logic [12:0]         phase_calc;
  logic [13:0]         count_calc;

  always_comb begin
    axis_y       = step_q[1];
    s_sel        = axis_y ? sh : sw;
    d_sel        = axis_y ? dh : dw;
    o_sel        = axis_y ? off_y_q : off_x_q;
    p_sel        = axis_y ? phase_y_q : phase_x_q;
    m_sel        = axis_y ? mode_y : mode_x;
    abs_o        = o_sel[12] ? (14'd0 - {o_sel[12], o_sel}) : {1'b0, o_sel};
    numer        = (d_sel > p_sel) ?
                   ({2'b00, d_sel} - {2'b00, p_sel} + {2'b00, s_sel} - 15'd1) : 15'd0;
    div_dividend = step_q[0] ? numer : {1'b0, abs_o};
    // A negative offset with a nonzero remainder folds back into [0, size).
    phase_calc   = (o_sel[12] && div_rem != 13'd0) ? (s_sel - div_rem) : div_rem;
    count_calc   = axis_count(m_sel, s_sel, d_sel, o_sel, p_sel, div_quo);
  end

  ftrg_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (s_sel),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Current tile and the walk advance.
  ftrg_pkg::tile_axis_t tile_x, tile_y;
  logic                 lead_x, lead_y;
  logic [13:0]          col_next, row_next;
  logic                 col_wrap, last_tile;

  always_comb begin
    tile_x    = axis_tile(mode_x, sw, dw, off_x_q, phase_x_q, col_idx_q == '0, pos_x_q);
    tile_y    = axis_tile(mode_y, sh, dh, off_y_q, phase_y_q, row_idx_q == '0, pos_y_q);
    lead_x    = (phase_x_q != '0) && (col_idx_q == '0);
    lead_y    = (phase_y_q != '0) && (row_idx_q == '0);
    col_next  = col_idx_q + 14'd1;
    row_next  = row_idx_q + 14'd1;
    col_wrap  = col_next >= col_cnt_q;
    last_tile = col_wrap && (row_next >= row_cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_x_q   <= '0;
      phase_y_q   <= '0;
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      col_idx_q   <= '0;
      row_idx_q   <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      walk_done_q <= 1'b1;
    end else begin
      // Setup results, one division at a time.
      if (state_q == ftrg_pkg::ST_DIV_WAIT && div_done) begin
        case (step_q)
          2'd0: phase_x_q <= phase_calc;
          2'd1: col_cnt_q <= count_calc;
          2'd2: phase_y_q <= phase_calc;
          default: begin
            row_cnt_q   <= count_calc;
            col_idx_q   <= '0;
            row_idx_q   <= '0;
            pos_x_q     <= {2'b00, phase_x_q};
            pos_y_q     <= {2'b00, phase_y_q};
            walk_done_q <= (col_cnt_q == '0) || (count_calc == '0);
          end
        endcase
      end
      // Step to the next column, or to the start of the next row.
      if (do_emit && !walk_done_q) begin
        if (col_wrap) begin
          col_idx_q <= '0;
          pos_x_q   <= {2'b00, phase_x_q};
          row_idx_q <= row_next;
          if (!lead_y) begin
            pos_y_q <= pos_y_q + {2'b00, sh};
          end
          if (last_tile) begin
            walk_done_q <= 1'b1;
          end
        end else begin
          col_idx_q <= col_next;
          if (!lead_x) begin
            pos_x_q <= pos_x_q + {2'b00, sw};
          end
        end
      end
      if (cfg_hit) begin
        walk_done_q <= 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_emit) begin
      if (walk_done_q) begin
        tile_valid_o <= 1'b0;
        src_left_o   <= '0;
        src_top_o    <= '0;
        src_span_x_o <= '0;
        src_span_y_o <= '0;
        dst_left_o   <= '0;
        dst_top_o    <= '0;
        dst_span_x_o <= '0;
        dst_span_y_o <= '0;
        final_tile_o <= 1'b0;
      end else begin
        tile_valid_o <= 1'b1;
        src_left_o   <= tile_x.src;
        src_top_o    <= tile_y.src;
        src_span_x_o <= tile_x.slen;
        src_span_y_o <= tile_y.slen;
        dst_left_o   <= tile_x.dst;
        dst_top_o    <= tile_y.dst;
        dst_span_x_o <= tile_x.dlen;
        dst_span_y_o <= tile_y.dlen;
        final_tile_o <= last_tile;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/ftrg_checker.sv @@
// Port-level checker of the tile rectangle generator, bound to the top level.
// Depends on the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "fill_tile_rect_generator_top_macros.svh"

module ftrg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        tile_valid_o,
  input wire logic [11:0] src_left_o,
  input wire logic [11:0] src_top_o,
  input wire logic [12:0] src_span_x_o,
  input wire logic [12:0] src_span_y_o,
  input wire logic [11:0] dst_left_o,
  input wire logic [11:0] dst_top_o,
  input wire logic [12:0] dst_span_x_o,
  input wire logic [12:0] dst_span_y_o,
  input wire logic        final_tile_o
);

  // A stalled result holds.
  `FTRG_ASSERT(a_out_hold,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tile_valid_o) &&
    $stable(src_left_o) && $stable(dst_left_o) && $stable(final_tile_o),
    "stalled result changed")

  // A finished walk answers with every field zero.
  `FTRG_ASSERT(a_empty_zero,
    out_valid_o && !tile_valid_o |-> final_tile_o == 1'b0 &&
    src_left_o == 12'd0 && src_top_o == 12'd0 &&
    src_span_x_o == 13'd0 && src_span_y_o == 13'd0 &&
    dst_left_o == 12'd0 && dst_top_o == 12'd0 &&
    dst_span_x_o == 13'd0 && dst_span_y_o == 13'd0,
    "empty answer has nonzero fields")

  // Every tile handed out covers at least one destination pixel.
  `FTRG_ASSERT(a_tile_nonempty,
    out_valid_o && tile_valid_o |-> dst_span_x_o != 13'd0 && dst_span_y_o != 13'd0,
    "tile with empty destination span")

  // No new request is taken while a result is held back.
  `FTRG_ASSERT(a_no_overrun, out_valid_o && out_stall_i |-> in_stall_o,
    "request accepted while result stalled")

  // Only a real tile can close a walk.
  `FTRG_ASSERT(a_final_valid, out_valid_o && final_tile_o |-> tile_valid_o,
    "final mark without tile")

endmodule

bind fill_tile_rect_generator_top ftrg_checker u_ftrg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .tile_valid_o (tile_valid_o),
  .src_left_o   (src_left_o),
  .src_top_o    (src_top_o),
  .src_span_x_o (src_span_x_o),
  .src_span_y_o (src_span_y_o),
  .dst_left_o   (dst_left_o),
  .dst_top_o    (dst_top_o),
  .dst_span_x_o (dst_span_x_o),
  .dst_span_y_o (dst_span_y_o),
  .final_tile_o (final_tile_o)
);

`default_nettype wire

@@ dv/fill_tile_rect_generator_top_test.sv @@
// Self-checking testbench for fill_tile_rect_generator_top.
// It predicts every tile rectangle from its own model of the walk and uses
// ftrg_pkg for register indexes, the axis rule enum and the tile axis struct.
`timescale 1ns / 1ps

module fill_tile_rect_generator_top_test;
  import ftrg_pkg::*;

  localparam int MaxDimension   = DefaultMaxDimension;
  localparam int RandomRequests = 450;
  localparam int WatchdogCycles = 4000;
  localparam int DrainCycles    = 100;

  // Bits of the fill mode register.
  localparam int RepeatXBit  = 0;
  localparam int RepeatYBit  = 1;
  localparam int StretchXBit = 2;
  localparam int StretchYBit = 3;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [CfgIndexW-1:0] CfgUnusedIndex = 3'd7;

  // One tile result as the block presents it.
  typedef struct packed {
    logic       tile_valid;
    tile_axis_t x;
    tile_axis_t y;
    logic       final_tile;
  } tile_rect_t;

  // Register copy, walk state and the queue of tiles still to arrive.
  class tile_scoreboard;
    logic [12:0] src_w, src_h, dst_w, dst_h, off_x, off_y;
    logic [3:0]  mode;
    int          phase_x, phase_y, col_count, row_count, col_idx, row_idx;
    bit          walk_done;
    tile_rect_t  expected_tiles[$];
    int          failures;

    function new();
      src_w = 1;
      src_h = 1;
      dst_w = 1;
      dst_h = 1;
      off_x = '0;
      off_y = '0;
      mode = '0;
      phase_x = 0;
      phase_y = 0;
      col_count = 0;
      row_count = 0;
      col_idx = 0;
      row_idx = 0;
      walk_done = 1'b1;
      failures = 0;
    endfunction

    function int clamp_size(logic [12:0] v);
      if (v > MaxDimension) return MaxDimension;
      return int'(v);
    endfunction

    function int min_of(int a, int b);
      return (a < b) ? a : b;
    endfunction

    // Repeat wins over stretch; neither bit means plain placement.
    function axis_mode_e axis_rule(bit rep, bit str);
      if (rep) return AXIS_REPEAT;
      if (str) return AXIS_STRETCH;
      return AXIS_PLAIN;
    endfunction

    // Phase and tile count of one axis, worked out on a restart.
    function void setup_axis(input int s, input int d, input int o, input axis_mode_e rule,
                             output int phase, output int count);
      int p;
      int ss;
      int ds;
      phase = 0;
      count = 0;
      if (s <= 0 || d <= 0) return;
      case (rule)
        AXIS_REPEAT: begin
          p = o % s;
          if (p < 0) p += s;
          count = (p > 0) ? 1 : 0;
          if (d > p) count += (d - p + s - 1) / s;
          phase = p;
        end
        AXIS_STRETCH: count = 1;
        default: begin
          ss = (o < 0) ? -o : 0;
          ds = (o > 0) ? o : 0;
          count = (min_of(s - ss, d - ds) > 0) ? 1 : 0;
        end
      endcase
    endfunction

    // Source and destination span of tile k along one axis.
    function tile_axis_t axis_tile(int s, int d, int o, axis_mode_e rule, int p, int k);
      tile_axis_t t;
      int src, slen, dst, dlen, pos;
      case (rule)
        AXIS_REPEAT: begin
          if (p > 0 && k == 0) begin
            // Leading partial tile comes from the far edge of the source.
            src = s - p;
            dst = 0;
            slen = min_of(p, d);
          end else begin
            pos = p + (k - ((p > 0) ? 1 : 0)) * s;
            src = 0;
            dst = pos;
            slen = min_of(s, d - pos);
          end
          dlen = slen;
        end
        AXIS_STRETCH: begin
          src = 0;
          dst = 0;
          slen = s;
          dlen = d;
        end
        default: begin
          src = (o < 0) ? -o : 0;
          dst = (o > 0) ? o : 0;
          slen = min_of(s - src, d - dst);
          dlen = slen;
        end
      endcase
      t.src = 12'(src);
      t.slen = 13'(slen);
      t.dst = 12'(dst);
      t.dlen = 13'(dlen);
      return t;
    endfunction

    // Any real register write ends the walk; the unused index does nothing.
    function void note_register_write(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgSourceWidth:  src_w = data;
        CfgSourceHeight: src_h = data;
        CfgTargetWidth:  dst_w = data;
        CfgTargetHeight: dst_h = data;
        CfgOffsetX:      off_x = data;
        CfgOffsetY:      off_y = data;
        CfgFillMode:     mode = data[3:0];
        default:         return;
      endcase
      walk_done = 1'b1;
    endfunction

    // Advance the walk for one accepted request and queue the tile it yields.
    function void note_request(bit restart);
      int sw, sh, dw, dh, ox, oy;
      axis_mode_e rule_x, rule_y;
      tile_rect_t tile;
      sw = clamp_size(src_w);
      sh = clamp_size(src_h);
      dw = clamp_size(dst_w);
      dh = clamp_size(dst_h);
      ox = $signed(off_x);
      oy = $signed(off_y);
      rule_x = axis_rule(mode[RepeatXBit], mode[StretchXBit]);
      rule_y = axis_rule(mode[RepeatYBit], mode[StretchYBit]);
      tile = '0;
      if (restart) begin
        setup_axis(sw, dw, ox, rule_x, phase_x, col_count);
        setup_axis(sh, dh, oy, rule_y, phase_y, row_count);
        col_idx = 0;
        row_idx = 0;
        walk_done = (col_count == 0 || row_count == 0);
      end
      if (!walk_done) begin
        tile.x = axis_tile(sw, dw, ox, rule_x, phase_x, col_idx);
        tile.y = axis_tile(sh, dh, oy, rule_y, phase_y, row_idx);
        col_idx++;
        if (col_idx >= col_count) begin
          col_idx = 0;
          row_idx++;
          if (row_idx >= row_count) walk_done = 1'b1;
        end
        tile.tile_valid = 1'b1;
        tile.final_tile = walk_done;
      end
      expected_tiles.push_back(tile);
    endfunction

    function int tiles_left();
      if (walk_done) return 0;
      return (row_count - row_idx) * col_count - col_idx;
    endfunction

    function int pending();
      return expected_tiles.size();
    endfunction

    function void compare_field(string field, logic [12:0] want, logic [12:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        failures++;
      end
    endfunction

    function void check_tile(tile_rect_t got);
      tile_rect_t want;
      if (expected_tiles.size() == 0) begin
        $display("%0t: tile result arrived with no request outstanding", $time);
        failures++;
        return;
      end
      want = expected_tiles.pop_front();
      compare_field("tile_valid", 13'(want.tile_valid), 13'(got.tile_valid));
      compare_field("src_left", 13'(want.x.src), 13'(got.x.src));
      compare_field("src_top", 13'(want.y.src), 13'(got.y.src));
      compare_field("src_span_x", want.x.slen, got.x.slen);
      compare_field("src_span_y", want.y.slen, got.y.slen);
      compare_field("dst_left", 13'(want.x.dst), 13'(got.x.dst));
      compare_field("dst_top", 13'(want.y.dst), 13'(got.y.dst));
      compare_field("dst_span_x", want.x.dlen, got.x.dlen);
      compare_field("dst_span_y", want.y.dlen, got.y.dlen);
      compare_field("final_tile", 13'(want.final_tile), 13'(got.final_tile));
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 restart_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 tile_valid_o;
  logic [11:0]          src_left_o;
  logic [11:0]          src_top_o;
  logic [12:0]          src_span_x_o;
  logic [12:0]          src_span_y_o;
  logic [11:0]          dst_left_o;
  logic [11:0]          dst_top_o;
  logic [12:0]          dst_span_x_o;
  logic [12:0]          dst_span_y_o;
  logic                 final_tile_o;

  tile_scoreboard sb;
  tile_rect_t     seen_tile;
  int             requests_sent;
  int             quiet_cycles;
  int             stall_run_left;
  bit             stall_now;

  fill_tile_rect_generator_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .tile_valid_o (tile_valid_o),
    .src_left_o   (src_left_o),
    .src_top_o    (src_top_o),
    .src_span_x_o (src_span_x_o),
    .src_span_y_o (src_span_y_o),
    .dst_left_o   (dst_left_o),
    .dst_top_o    (dst_top_o),
    .dst_span_x_o (dst_span_x_o),
    .dst_span_y_o (dst_span_y_o),
    .final_tile_o (final_tile_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Result side: check each accepted tile, then pick the next stall level.
  // Runs of stall are mostly short with a few long ones; free runs vary widely.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_tile.tile_valid = tile_valid_o;
      seen_tile.x.src = src_left_o;
      seen_tile.x.slen = src_span_x_o;
      seen_tile.x.dst = dst_left_o;
      seen_tile.x.dlen = dst_span_x_o;
      seen_tile.y.src = src_top_o;
      seen_tile.y.slen = src_span_y_o;
      seen_tile.y.dst = dst_top_o;
      seen_tile.y.dlen = dst_span_y_o;
      seen_tile.final_tile = final_tile_o;
      sb.check_tile(seen_tile);
    end
    if (stall_run_left == 0) begin
      stall_now = ($urandom_range(0, 2) == 0);
      if (!stall_now) stall_run_left = $urandom_range(1, 30);
      else if ($urandom_range(0, 9) < 8) stall_run_left = $urandom_range(1, 3);
      else stall_run_left = $urandom_range(10, 40);
    end
    stall_run_left--;
    out_stall_i <= stall_now;
  end

  // Watchdog: too long without any handshake or register write ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WatchdogCycles) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sender gap: often none, usually a few cycles, now and then a long one.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sizes are mostly small so walks end; the rest hit zero, saturation and random values.
  function int size_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 16);
    if (r < 78) return 0;
    if (r < 84) return MaxDimension;
    if (r < 88) return 8191;
    if (r < 92) return MaxDimension + 1;
    return $urandom_range(0, 8191);
  endfunction

  // Destination size kept to a few source tiles most of the time.
  function int target_value(int s);
    int sc;
    sc = (s < 1) ? 1 : ((s > 16) ? 16 : s);
    if ($urandom_range(0, 99) < 75) return $urandom_range(1, 3 * sc + 2);
    return size_value();
  endfunction

  function int offset_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 80) - 40;
    if (r < 70) return -4096;
    if (r < 80) return 4095;
    return $urandom_range(0, 8191);
  endfunction

  // One register write; the caller lowers the write enable after the last one.
  task automatic write_register(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.note_register_write(idx, data);
  endtask

  task automatic program_all(int sw, int sh, int dw, int dh, int ox, int oy, int fm);
    write_register(CfgSourceWidth, 13'(sw));
    write_register(CfgSourceHeight, 13'(sh));
    write_register(CfgTargetWidth, 13'(dw));
    write_register(CfgTargetHeight, 13'(dh));
    write_register(CfgOffsetX, 13'(ox));
    write_register(CfgOffsetY, 13'(oy));
    write_register(CfgFillMode, 13'(fm));
    cfg_we_i <= 1'b0;
  endtask

  // Rewrite a random subset of registers (all of them when asked).
  task automatic randomize_registers(bit all_regs);
    int s_x, s_y;
    bit wrote;
    wrote = 1'b0;
    s_x = size_value();
    s_y = size_value();
    if (all_regs || $urandom_range(0, 1)) begin
      write_register(CfgSourceWidth, 13'(s_x));
      wrote = 1'b1;
    end
    if (all_regs || $urandom_range(0, 1)) begin
      write_register(CfgSourceHeight, 13'(s_y));
      wrote = 1'b1;
    end
    if (all_regs || $urandom_range(0, 1)) begin
      write_register(CfgTargetWidth, 13'(target_value(s_x)));
      wrote = 1'b1;
    end
    if (all_regs || $urandom_range(0, 1)) begin
      write_register(CfgTargetHeight, 13'(target_value(s_y)));
      wrote = 1'b1;
    end
    if (all_regs || $urandom_range(0, 1)) begin
      write_register(CfgOffsetX, 13'(offset_value()));
      wrote = 1'b1;
    end
    if (all_regs || $urandom_range(0, 1)) begin
      write_register(CfgOffsetY, 13'(offset_value()));
      wrote = 1'b1;
    end
    if (all_regs || $urandom_range(0, 1)) begin
      // Upper data bits of the mode write are ignored by the block.
      if ($urandom_range(0, 99) < 85) write_register(CfgFillMode, 13'($urandom_range(0, 15)));
      else write_register(CfgFillMode, 13'($urandom_range(0, 8191)));
      wrote = 1'b1;
    end
    if ($urandom_range(0, 9) == 0) begin
      write_register(CfgUnusedIndex, 13'($urandom_range(0, 8191)));
      wrote = 1'b1;
    end
    if (wrote) cfg_we_i <= 1'b0;
  endtask

  // One request; valid stays high afterwards so back-to-back requests are possible.
  task automatic send_request(bit restart, bit no_gaps);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i <= restart;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(restart);
    requests_sent++;
  endtask

  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Main sequence: reset, directed walks, then random phases.
  initial begin
    int n;
    int shape;
    int random_base;
    bit no_gaps;
    bit first_phase;
    sb = new();
    requests_sent = 0;
    quiet_cycles = 0;
    stall_run_left = 0;
    stall_now = 1'b0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    restart_i <= 1'b0;
    out_stall_i <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // No walk after reset, then the single plain tile of the reset sizes.
    send_request(1'b0, 1'b0);
    send_request(1'b1, 1'b0);
    send_request(1'b0, 1'b0);
    in_valid_i <= 1'b0;

    // Repeat on both axes with leading partial tiles, walked past its end.
    wait_idle();
    program_all(5, 3, 12, 7, -2, 4, (1 << RepeatXBit) | (1 << RepeatYBit));
    send_request(1'b1, 1'b1);
    repeat (9) send_request(1'b0, 1'b1);
    in_valid_i <= 1'b0;

    // Stretch on both axes with oversize source width.
    wait_idle();
    program_all(8191, MaxDimension, MaxDimension, 1, 0, 0,
                (1 << StretchXBit) | (1 << StretchYBit));
    send_request(1'b1, 1'b0);
    send_request(1'b0, 1'b0);
    in_valid_i <= 1'b0;

    // Zero source width gives an empty walk.
    wait_idle();
    write_register(CfgSourceWidth, 13'(0));
    cfg_we_i <= 1'b0;
    send_request(1'b1, 1'b0);
    in_valid_i <= 1'b0;

    // Plain placement at the largest offset, clipped to one column.
    wait_idle();
    program_all(10, 1, MaxDimension, 1, 4095, 0, 0);
    send_request(1'b1, 1'b0);
    in_valid_i <= 1'b0;

    // Most negative offset puts the plain tile wholly outside.
    wait_idle();
    write_register(CfgOffsetX, 13'(-4096));
    cfg_we_i <= 1'b0;
    send_request(1'b1, 1'b0);
    in_valid_i <= 1'b0;

    // Repeat and stretch together; an unused index leaves the walk alone,
    // a real register write ends it.
    wait_idle();
    program_all(3, 2, 7, 5, 1, -1, 15);
    send_request(1'b1, 1'b0);
    send_request(1'b0, 1'b0);
    in_valid_i <= 1'b0;
    wait_idle();
    write_register(CfgUnusedIndex, 13'h1fff);
    cfg_we_i <= 1'b0;
    send_request(1'b0, 1'b0);
    in_valid_i <= 1'b0;
    wait_idle();
    write_register(CfgFillMode, 13'(15));
    cfg_we_i <= 1'b0;
    send_request(1'b0, 1'b0);
    in_valid_i <= 1'b0;

    // Random phases: mostly a restart followed by the rest of its walk.
    random_base = requests_sent;
    first_phase = 1'b1;
    while (requests_sent - random_base < RandomRequests) begin
      wait_idle();
      if (first_phase || $urandom_range(0, 2) != 0) randomize_registers(first_phase);
      first_phase = 1'b0;
      no_gaps = ($urandom_range(0, 3) == 0);
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
        repeat ($urandom_range(1, 4)) send_request(1'b0, no_gaps);
      end else if (shape == 1) begin
        repeat ($urandom_range(1, 8)) send_request($urandom_range(0, 1), no_gaps);
      end else begin
        send_request(1'b1, no_gaps);
        n = sb.tiles_left() + $urandom_range(0, 2);
        if (n > 40) n = 40;
        repeat (n) send_request(1'b0, no_gaps);
      end
      in_valid_i <= 1'b0;
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.pending() != 0)
      $display("%0t: %0d tile results never arrived", $time, sb.pending());
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ftrg_pkg.sv
rtl/ftrg_divider.sv
rtl/fill_tile_rect_generator_top.sv
rtl/ftrg_checker.sv
dv/fill_tile_rect_generator_top_test.sv
